// File: rtl/tsk_pkg.sv
// ----------------------------------------------------------------------------
// tsk_pkg: shared types and codes for the topological sort block
// Beat payloads, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package tsk_pkg;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	localparam logic [1:0] ST_EMIT  = 2'd0;
	localparam logic [1:0] ST_CYCLE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic       operation;
		logic [5:0] src_vertex;
		logic [5:0] dst_vertex;
	} in_item_t;

	typedef struct packed {
		logic [5:0] vertex;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_WR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DEC_RD,
		S_DEC_WR,
		S_FINAL,
		S_CLEAR
	} state_t;

endpackage

// File: rtl/tsk_ram.sv
// ----------------------------------------------------------------------------
// tsk_ram: generic simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tsk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/topological_sort_kahn_top.sv
// ----------------------------------------------------------------------------
// topological_sort_kahn_top: edge store and Kahn topological sort
// Add-edge beat: accept, row/degree read, write back; no result.
// Run beat: accept; per pass each vertex scanned is read and checked, then the pass closes;
//   an emitted vertex reads each candidate successor, writes back per stored edge, ends its row;
//   up to vertex_count passes, a status beat on a cycle or empty graph, then a clear step.
//   A held result beat stalls the scan. Reset clears per-row valid bits so both rams read zero.
// ----------------------------------------------------------------------------
module topological_sort_kahn_top #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  tsk_pkg::in_item_t    item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output tsk_pkg::out_item_t   result
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int EW = CW + 1;

	tsk_pkg::state_t state_q, state_d;

	logic [CW-1:0]           vc_q, i_q, j_q, emitted_q;
	logic                    progress_q;
	logic [VW-1:0]           src_q, dst_q;
	logic                    edge_ok_q;
	logic [MAX_VERTICES-1:0] row_q;
	logic [MAX_VERTICES-1:0] adj_vld_q, deg_vld_q;
	logic                    adj_rd_vld_q, deg_rd_vld_q;
	logic                    out_valid_q;
	tsk_pkg::out_item_t      out_q, out_d;

	logic                    adj_rd_en, adj_wr_en, deg_rd_en, deg_wr_en;
	logic [VW-1:0]           adj_rd_addr, adj_wr_addr, deg_rd_addr, deg_wr_addr;
	logic [MAX_VERTICES-1:0] adj_rd_data, adj_wr_data;
	logic [EW-1:0]           deg_rd_data, deg_wr_data;

	logic                    accept, out_take, out_free, out_load;
	logic [8:0]              src_w, dst_w, top_w;
	logic                    edge_in;
	logic [VW-1:0]           i_idx, j_idx;
	logic                    i_end, j_end;
	logic [MAX_VERTICES-1:0] row_cur;
	logic [EW-1:0]           deg_cur;
	logic                    eligible, scan_emit;

	tsk_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
		.clk     (clk),
		.wr_en   (adj_wr_en),
		.wr_addr (adj_wr_addr),
		.wr_data (adj_wr_data),
		.rd_en   (adj_rd_en),
		.rd_addr (adj_rd_addr),
		.rd_data (adj_rd_data)
	);

	// entry layout: visited flag on top, in-degree below
	tsk_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_deg_ram (
		.clk     (clk),
		.wr_en   (deg_wr_en),
		.wr_addr (deg_wr_addr),
		.wr_data (deg_wr_data),
		.rd_en   (deg_rd_en),
		.rd_addr (deg_rd_addr),
		.rd_data (deg_rd_data)
	);

	assign item_stall   = (state_q != tsk_pkg::S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_take     = out_valid_q && !result_stall;
	assign out_free     = !out_valid_q || !result_stall;

	assign src_w   = 9'(item.src_vertex);
	assign dst_w   = 9'(item.dst_vertex);
	assign edge_in = (src_w < 9'(MAX_VERTICES)) && (dst_w < 9'(MAX_VERTICES));
	assign top_w   = ((src_w > dst_w) ? src_w : dst_w) + 9'd1;

	assign i_idx = i_q[VW-1:0];
	assign j_idx = j_q[VW-1:0];
	assign i_end = (i_q >= vc_q);
	assign j_end = (j_q >= vc_q);

	// entries never written since the last clear read as zero
	assign row_cur  = adj_rd_vld_q ? adj_rd_data : '0;
	assign deg_cur  = deg_rd_vld_q ? deg_rd_data : '0;
	assign eligible = !deg_cur[EW-1] && (deg_cur[CW-1:0] == '0);
	assign scan_emit = (state_q == tsk_pkg::S_SCAN_CHK) && eligible && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tsk_pkg::S_IDLE: begin
				if (accept) begin
					if (item.operation == tsk_pkg::OP_ADD) begin
						state_d = tsk_pkg::S_ADD_RD;
					end else if (vc_q == '0) begin
						state_d = tsk_pkg::S_FINAL;
					end else begin
						state_d = tsk_pkg::S_SCAN_RD;
					end
				end
			end
			tsk_pkg::S_ADD_RD: state_d = tsk_pkg::S_ADD_WR;
			tsk_pkg::S_ADD_WR: state_d = tsk_pkg::S_IDLE;
			tsk_pkg::S_SCAN_RD: begin
				if (!i_end) begin
					state_d = tsk_pkg::S_SCAN_CHK;
				end else if (emitted_q == vc_q) begin
					state_d = tsk_pkg::S_CLEAR;
				end else if (!progress_q) begin
					state_d = tsk_pkg::S_FINAL;
				end
			end
			tsk_pkg::S_SCAN_CHK: begin
				if (!eligible) begin
					state_d = tsk_pkg::S_SCAN_RD;
				end else if (out_free) begin
					state_d = tsk_pkg::S_DEC_RD;
				end
			end
			tsk_pkg::S_DEC_RD: begin
				if (j_end) begin
					state_d = tsk_pkg::S_SCAN_RD;
				end else if (row_q[j_idx]) begin
					state_d = tsk_pkg::S_DEC_WR;
				end
			end
			tsk_pkg::S_DEC_WR: state_d = tsk_pkg::S_DEC_RD;
			tsk_pkg::S_FINAL: begin
				if (out_free) begin
					state_d = tsk_pkg::S_CLEAR;
				end
			end
			tsk_pkg::S_CLEAR: state_d = tsk_pkg::S_IDLE;
			default: state_d = tsk_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		adj_rd_en   = 1'b0;
		adj_rd_addr = src_q;
		adj_wr_en   = 1'b0;
		adj_wr_addr = src_q;
		adj_wr_data = row_cur | (MAX_VERTICES'(1) << dst_q);
		deg_rd_en   = 1'b0;
		deg_rd_addr = dst_q;
		deg_wr_en   = 1'b0;
		deg_wr_addr = dst_q;
		deg_wr_data = deg_cur + EW'(1);
		out_load    = 1'b0;
		out_d.vertex = 6'(i_q);
		out_d.status = tsk_pkg::ST_EMIT;
		out_d.last   = (CW'(emitted_q + 1'b1) == vc_q);
		case (state_q)
			tsk_pkg::S_ADD_RD: begin
				adj_rd_en = 1'b1;
				deg_rd_en = 1'b1;
			end
			tsk_pkg::S_ADD_WR: begin
				// a duplicate edge leaves row and degree as they are
				if (edge_ok_q && !row_cur[dst_q]) begin
					adj_wr_en = 1'b1;
					deg_wr_en = 1'b1;
				end
			end
			tsk_pkg::S_SCAN_RD: begin
				adj_rd_addr = i_idx;
				deg_rd_addr = i_idx;
				if (!i_end) begin
					adj_rd_en = 1'b1;
					deg_rd_en = 1'b1;
				end
			end
			tsk_pkg::S_SCAN_CHK: begin
				deg_wr_addr = i_idx;
				deg_wr_data = {1'b1, {CW{1'b0}}};
				if (scan_emit) begin
					deg_wr_en = 1'b1;
					out_load  = 1'b1;
				end
			end
			tsk_pkg::S_DEC_RD: begin
				deg_rd_addr = j_idx;
				if (!j_end && row_q[j_idx]) begin
					deg_rd_en = 1'b1;
				end
			end
			tsk_pkg::S_DEC_WR: begin
				deg_wr_addr = j_idx;
				deg_wr_data = deg_cur - EW'(1);
				if (deg_cur[CW-1:0] != '0) begin
					deg_wr_en = 1'b1;
				end
			end
			tsk_pkg::S_FINAL: begin
				out_d.vertex = '0;
				out_d.status = (vc_q == '0) ? tsk_pkg::ST_EMPTY : tsk_pkg::ST_CYCLE;
				out_d.last   = 1'b1;
				out_load     = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsk_pkg::S_IDLE;
			vc_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			emitted_q   <= '0;
			progress_q  <= 1'b0;
			adj_vld_q   <= '0;
			deg_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == tsk_pkg::S_CLEAR) begin
				adj_vld_q <= '0;
				deg_vld_q <= '0;
				vc_q      <= '0;
			end else begin
				if (adj_wr_en) begin
					adj_vld_q[adj_wr_addr] <= 1'b1;
				end
				if (deg_wr_en) begin
					deg_vld_q[deg_wr_addr] <= 1'b1;
				end
				if (accept && item.operation == tsk_pkg::OP_ADD && edge_in
						&& top_w > 9'(vc_q)) begin
					vc_q <= CW'(top_w);
				end
			end

			if (accept) begin
				i_q        <= '0;
				emitted_q  <= '0;
				progress_q <= 1'b0;
			end

			case (state_q)
				tsk_pkg::S_SCAN_RD: begin
					// start a new pass while progress is still being made
					if (i_end) begin
						i_q        <= '0;
						progress_q <= 1'b0;
					end
				end
				tsk_pkg::S_SCAN_CHK: begin
					if (!eligible) begin
						i_q <= i_q + 1'b1;
					end else if (scan_emit) begin
						emitted_q  <= emitted_q + 1'b1;
						progress_q <= 1'b1;
						j_q        <= '0;
					end
				end
				tsk_pkg::S_DEC_RD: begin
					if (j_end) begin
						i_q <= i_q + 1'b1;
					end else if (!row_q[j_idx]) begin
						j_q <= j_q + 1'b1;
					end
				end
				tsk_pkg::S_DEC_WR: begin
					j_q <= j_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q     <= src_w[VW-1:0];
			dst_q     <= dst_w[VW-1:0];
			edge_ok_q <= edge_in;
		end
		if (adj_rd_en) begin
			adj_rd_vld_q <= adj_vld_q[adj_rd_addr];
		end
		if (deg_rd_en) begin
			deg_rd_vld_q <= deg_vld_q[deg_rd_addr];
		end
		if (scan_emit) begin
			row_q <= row_cur;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

endmodule

// File: tb/kahn_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kahn_order_checker: edge store and topological order predictor
// Watches both channels. Edge beats update a private copy of the graph. Each
// run beat computes the Kahn order that the block must produce, and result
// beats are compared with it field by field, oldest first.
// ----------------------------------------------------------------------------
module kahn_order_checker #(
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  tsk_pkg::in_item_t  item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  tsk_pkg::out_item_t result,
	output int                 mismatches,
	output int                 pending
);

	logic [MAX_VERTICES-1:0] succ_row [MAX_VERTICES];
	logic [6:0]              pred_count [MAX_VERTICES];
	logic                    placed_flag [MAX_VERTICES];
	int unsigned             vertex_total;

	tsk_pkg::out_item_t expected_order [$];

	task automatic wipe_graph();
		for (int v = 0; v < MAX_VERTICES; v++) begin
			succ_row[v]    = '0;
			pred_count[v]  = '0;
			placed_flag[v] = 1'b0;
		end
		vertex_total = 0;
	endtask

	task automatic store_edge(input logic [5:0] src, input logic [5:0] dst);
		int unsigned top;
		if (src >= MAX_VERTICES || dst >= MAX_VERTICES)
			return;
		top = ((src > dst) ? src : dst) + 1;
		if (top > vertex_total)
			vertex_total = top;
		// a repeated edge leaves the in-degree alone
		if (!succ_row[src][dst]) begin
			succ_row[src][dst] = 1'b1;
			pred_count[dst]    = pred_count[dst] + 7'd1;
		end
	endtask

	task automatic sort_graph();
		tsk_pkg::out_item_t r;
		int unsigned        placed;
		bit                 moved;
		if (vertex_total == 0) begin
			r.vertex = '0;
			r.status = tsk_pkg::ST_EMPTY;
			r.last   = 1'b1;
			expected_order.push_back(r);
		end else begin
			placed = 0;
			moved  = 1'b1;
			while (placed < vertex_total && moved) begin
				moved = 1'b0;
				for (int v = 0; v < vertex_total && v < MAX_VERTICES; v++) begin
					if (!placed_flag[v] && pred_count[v] == 0) begin
						moved          = 1'b1;
						placed_flag[v] = 1'b1;
						placed++;
						r.vertex = v[5:0];
						r.status = tsk_pkg::ST_EMIT;
						// the vertex that completes the order closes the run
						r.last   = (placed == vertex_total);
						expected_order.push_back(r);
						// successors drop at once, so later indices may go in this pass
						for (int w = 0; w < vertex_total && w < MAX_VERTICES; w++) begin
							if (succ_row[v][w] && pred_count[w] != 0)
								pred_count[w] = pred_count[w] - 7'd1;
						end
					end
				end
			end
			if (placed < vertex_total) begin
				r.vertex = '0;
				r.status = tsk_pkg::ST_CYCLE;
				r.last   = 1'b1;
				expected_order.push_back(r);
			end
		end
		wipe_graph();
	endtask

	always @(posedge clk) begin : watch
		tsk_pkg::out_item_t want;
		if (!arst_n) begin
			mismatches = 0;
			pending    = 0;
			expected_order.delete();
			wipe_graph();
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_order.size() == 0) begin
					$error("result beat with none expected: vertex %0d status %0d last %0d",
						result.vertex, result.status, result.last);
					mismatches++;
				end else begin
					want = expected_order.pop_front();
					if (result.vertex !== want.vertex) begin
						$error("vertex: expected %0d, actual %0d", want.vertex, result.vertex);
						mismatches++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, result.status);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, result.last);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (item.operation == tsk_pkg::OP_ADD)
					store_edge(item.src_vertex, item.dst_vertex);
				else
					sort_graph();
			end
			pending = expected_order.size();
		end
	end

endmodule

// File: tb/topological_sort_kahn_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topological_sort_kahn_top_tb: stimulus and verdict for the sort block
// Directed graphs cover the empty run, duplicates, self-loops, cycles and
// gaps in numbering; then random graphs, mostly acyclic under a shuffled
// numbering, some with a closed cycle and some plain noise. Both channels
// idle at random; checking is done by kahn_order_checker.
// ----------------------------------------------------------------------------
module topological_sort_kahn_top_tb;

	localparam int NUM_ITEMS = 280;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	tsk_pkg::in_item_t  item;
	logic               result_valid;
	logic               result_stall;
	tsk_pkg::out_item_t result;
	int                 mismatches;
	int                 pending;

	int sent;
	bit tx_calm;

	topological_sort_kahn_top #(
		.MAX_VERTICES(64)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	kahn_order_checker #(
		.MAX_VERTICES(64)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// entered and left at a falling edge; valid stays high into a back-to-back beat
	task automatic send_item(input logic op, input logic [5:0] src, input logic [5:0] dst);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{operation: op, src_vertex: src, dst_vertex: dst};
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		sent++;
	endtask

	initial begin : stimulus
		int rank_of [64];
		int span, n_edges, shape, a, b, j, tmp;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		sent         = 0;
		tx_calm      = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty graph straight after reset
		send_item(tsk_pkg::OP_RUN, 6'd0, 6'd0);
		// small chain with a repeated edge
		send_item(tsk_pkg::OP_ADD, 6'd0, 6'd1);
		send_item(tsk_pkg::OP_ADD, 6'd1, 6'd2);
		send_item(tsk_pkg::OP_ADD, 6'd0, 6'd2);
		send_item(tsk_pkg::OP_ADD, 6'd0, 6'd1);
		send_item(tsk_pkg::OP_RUN, 6'd63, 6'd63);
		// unused indices below the top, plus a self-loop that blocks its vertex
		send_item(tsk_pkg::OP_ADD, 6'd63, 6'd0);
		send_item(tsk_pkg::OP_ADD, 6'd5, 6'd63);
		send_item(tsk_pkg::OP_ADD, 6'd2, 6'd2);
		send_item(tsk_pkg::OP_RUN, 6'd42, 6'd21);
		// two-vertex cycle
		send_item(tsk_pkg::OP_ADD, 6'd42, 6'd21);
		send_item(tsk_pkg::OP_ADD, 6'd21, 6'd42);
		send_item(tsk_pkg::OP_RUN, 6'd21, 6'd42);
		// widest graph, finishes cleanly
		send_item(tsk_pkg::OP_ADD, 6'd62, 6'd63);
		send_item(tsk_pkg::OP_RUN, 6'd0, 6'd63);

		while (sent < NUM_ITEMS) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			span    = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(2, 12);
			n_edges = $urandom_range(0, (span == 64) ? 40 : 2 * span);
			shape   = $urandom_range(0, 19);
			for (int i = 0; i < span; i++)
				rank_of[i] = i;
			for (int i = span - 1; i > 0; i--) begin
				j          = $urandom_range(0, i);
				tmp        = rank_of[i];
				rank_of[i] = rank_of[j];
				rank_of[j] = tmp;
			end
			for (int e = 0; e < n_edges; e++) begin
				if (shape >= 17) begin
					// noise: any pair, self-loops included
					a = $urandom_range(0, span - 1);
					b = $urandom_range(0, span - 1);
					send_item(tsk_pkg::OP_ADD, a[5:0], b[5:0]);
				end else begin
					// forward in shuffled rank, so the graph stays acyclic
					a = $urandom_range(0, span - 2);
					b = $urandom_range(a + 1, span - 1);
					send_item(tsk_pkg::OP_ADD, rank_of[a][5:0], rank_of[b][5:0]);
				end
			end
			if (shape >= 14 && shape <= 16) begin
				// closed loop on top of the acyclic part
				a = $urandom_range(0, span - 2);
				b = $urandom_range(a + 1, span - 1);
				send_item(tsk_pkg::OP_ADD, rank_of[a][5:0], rank_of[b][5:0]);
				send_item(tsk_pkg::OP_ADD, rank_of[b][5:0], rank_of[a][5:0]);
			end
			a = $urandom_range(0, 63);
			b = $urandom_range(0, 63);
			send_item(tsk_pkg::OP_RUN, a[5:0], b[5:0]);
		end
		item_valid <= 1'b0;

		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : result_side
		int  hold;
		int  span_left;
		bit  rx_calm;
		result_stall = 1'b0;
		span_left    = 0;
		rx_calm      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (span_left == 0) begin
				span_left = $urandom_range(8, 40);
				rx_calm   = ($urandom_range(0, 3) == 0);
			end
			span_left--;
			hold = rx_calm ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	initial begin : watchdog
		#60ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/tsk_pkg.sv
rtl/tsk_ram.sv
rtl/topological_sort_kahn_top.sv
tb/kahn_order_checker.sv
tb/topological_sort_kahn_top_tb.sv
